### src/sspp_pkg.sv
// ----------------------------------------------------------------------------
// sspp_pkg
// Shared types and constants for the servo status packet parser.
// ----------------------------------------------------------------------------
package sspp_pkg;

  // Longest reply that is tracked; the byte index saturates one below this.
  localparam int unsigned MaxReplyBytes = 256;
  localparam logic [7:0]  IdxCap        = 8'(MaxReplyBytes - 1);

  // Fixed byte positions in a status reply.
  localparam logic [7:0] IdxHeaderEnd = 8'd2;   // bytes 0 and 1 are header
  localparam logic [7:0] IdxError     = 8'd4;
  localparam logic [7:0] IdxValueLow  = 8'd5;
  localparam logic [7:0] IdxValueHigh = 8'd6;
  localparam logic [7:0] IdxMinLast   = 8'd5;   // last index of a 6-byte reply
  localparam logic [7:0] IdxWideLast  = 8'd7;   // last index of an 8-byte reply

  // Reset values of the configuration registers.
  localparam logic [7:0]  HeaderReset = 8'd255;
  localparam logic [15:0] AlarmReset  = 16'd100;
  localparam logic [15:0] CountMax    = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic {
    CFG_HEADER_VALUE    = 1'b0,
    CFG_ALARM_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_REPLY    = 3'd1,
    ST_TOO_SHORT   = 3'd2,
    ST_BAD_HEADER  = 3'd3,
    ST_BAD_CHECKSUM = 3'd4,
    ST_DEVICE_ERROR = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
    logic       no_reply;
  } in_item_t;

  typedef struct packed {
    status_e     status_code;
    logic [7:0]  error_flags;
    logic [15:0] reply_value;
    logic [15:0] failure_count;
    logic        alarm;
  } out_item_t;

  // Classified reply, passed from the front end to the back end.
  typedef struct packed {
    status_e     status_code;
    logic [7:0]  error_flags;
    logic [15:0] reply_value;
  } verdict_t;

  // Queue handshake between the two halves.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/sspp_front.sv
// ----------------------------------------------------------------------------
// sspp_front
// Byte-level reply tracking and classification into a verdict.
// ----------------------------------------------------------------------------
module sspp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  sspp_pkg::in_item_t item_i,
  input  logic [7:0]        header_value_i,
  output logic              verdict_push_o,
  output sspp_pkg::verdict_t verdict_o
);
  import sspp_pkg::*;

  logic [7:0] idx_q, idx_d;
  logic       hdr_ok_q, hdr_ok_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] err_q, err_d;
  logic [7:0] vlo_q, vlo_d;
  logic [7:0] vhi_q, vhi_d;

  logic       final_item;
  logic [7:0] b;
  status_e    code;

  assign b          = item_i.rx_byte;
  assign final_item = accept_i & (item_i.no_reply | item_i.last_byte);

  // Fields as they stand with the current byte folded in.
  always_comb begin
    hdr_ok_d = hdr_ok_q;
    err_d    = err_q;
    vlo_d    = vlo_q;
    vhi_d    = vhi_q;
    if (idx_q < IdxHeaderEnd && b != header_value_i) begin
      hdr_ok_d = 1'b0;
    end
    if (idx_q == IdxError) begin
      err_d = b;
    end
    if (idx_q == IdxValueLow) begin
      vlo_d = b;
    end
    if (idx_q == IdxValueHigh) begin
      vhi_d = b;
    end
    sum_d = sum_q;
    idx_d = idx_q;
    if (idx_q < IdxCap) begin
      if (idx_q >= IdxHeaderEnd) begin
        sum_d = sum_q + b;
      end
      idx_d = idx_q + 8'd1;
    end
  end

  always_comb begin
    priority if (item_i.no_reply) begin
      code = ST_NO_REPLY;
    end else if (idx_q < IdxMinLast) begin
      code = ST_TOO_SHORT;
    end else if (!hdr_ok_d) begin
      code = ST_BAD_HEADER;
    end else if (~sum_q != b) begin
      code = ST_BAD_CHECKSUM;
    end else if (err_d != 8'd0) begin
      code = ST_DEVICE_ERROR;
    end else begin
      code = ST_OK;
    end
  end

  always_comb begin
    verdict_o.status_code = code;
    verdict_o.error_flags = (code == ST_OK || code == ST_DEVICE_ERROR) ? err_d : 8'd0;
    verdict_o.reply_value = 16'd0;
    if (code == ST_OK) begin
      verdict_o.reply_value = (idx_q >= IdxWideLast) ? {vhi_d, vlo_d} : {8'd0, vlo_d};
    end
  end

  assign verdict_push_o = final_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 8'd0;
      hdr_ok_q <= 1'b1;
      sum_q    <= 8'd0;
      err_q    <= 8'd0;
      vlo_q    <= 8'd0;
      vhi_q    <= 8'd0;
    end else if (final_item) begin
      idx_q    <= 8'd0;
      hdr_ok_q <= 1'b1;
      sum_q    <= 8'd0;
      err_q    <= 8'd0;
      vlo_q    <= 8'd0;
      vhi_q    <= 8'd0;
    end else if (accept_i) begin
      idx_q    <= idx_d;
      hdr_ok_q <= hdr_ok_d;
      sum_q    <= sum_d;
      err_q    <= err_d;
      vlo_q    <= vlo_d;
      vhi_q    <= vhi_d;
    end
  end

endmodule

### src/sspp_vq.sv
// ----------------------------------------------------------------------------
// sspp_vq
// Two-entry verdict queue between front end and back end.
// ----------------------------------------------------------------------------
module sspp_vq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sspp_pkg::verdict_t  item_i,
  input  logic                pop_i,
  output sspp_pkg::q_status_t status_o,
  output sspp_pkg::verdict_t  item_o
);
  import sspp_pkg::*;

  verdict_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### src/sspp_back.sv
// ----------------------------------------------------------------------------
// sspp_back
// Failure counter, alarm compare and two-entry result queue.
// ----------------------------------------------------------------------------
module sspp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sspp_pkg::q_status_t vq_status_i,
  input  sspp_pkg::verdict_t  verdict_i,
  output logic                vq_pop_o,
  input  logic [15:0]         alarm_threshold_i,
  input  logic                pop_i,
  output logic                empty_o,
  output sspp_pkg::out_item_t item_o
);
  import sspp_pkg::*;

  logic [15:0] fail_q, fail_d;
  out_item_t   mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        do_pop;
  out_item_t   res;

  assign vq_pop_o = ~vq_status_i.empty & (cnt_q != 2'd2);
  assign empty_o  = (cnt_q == 2'd0);
  assign do_pop   = pop_i & ~empty_o;
  assign item_o   = mem_q[rd_q];

  always_comb begin
    if (verdict_i.status_code == ST_OK) begin
      fail_d = (fail_q == 16'd0) ? fail_q : fail_q - 16'd1;
    end else begin
      fail_d = (fail_q == CountMax) ? fail_q : fail_q + 16'd1;
    end
    res.status_code   = verdict_i.status_code;
    res.error_flags   = verdict_i.error_flags;
    res.reply_value   = verdict_i.reply_value;
    res.failure_count = fail_d;
    res.alarm         = (fail_d > alarm_threshold_i);
  end

  always_ff @(posedge clk_i) begin
    if (vq_pop_o) begin
      mem_q[wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q <= 16'd0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (vq_pop_o) begin
        fail_q <= fail_d;
        wr_q   <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, vq_pop_o} - {1'b0, do_pop};
    end
  end

endmodule

### src/servo_status_packet_parser.sv
// ----------------------------------------------------------------------------
// servo_status_packet_parser
// Byte-wise parser for servo status replies with failure tracking.
// ----------------------------------------------------------------------------
// One transfer on the push side carries one reply byte (last_byte marks the
// end of a burst) or a no-reply marker; a byte can be pushed on every clock
// while full is low. Bytes before the last only update the burst state; the
// last byte or a no-reply marker yields one result, which is registered first
// in the verdict queue and then, with the updated failure counter, in the
// result queue before it shows up on the result side. The front end
// classifies the burst, a two-entry verdict queue decouples it from the back
// end, which updates the saturating failure counter, compares it against the
// alarm threshold and holds up to two finished results. full only rises when
// results back up behind a stalled pop. Configuration writes take effect the
// next cycle and should only be issued while the parser is idle.
// ----------------------------------------------------------------------------
module servo_status_packet_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input side
  input  logic                push,
  output logic                full,
  input  sspp_pkg::in_item_t  in_item_i,
  // result side
  output logic                empty,
  input  logic                pop,
  output sspp_pkg::out_item_t out_item_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);
  import sspp_pkg::*;

  logic [7:0]  header_q;
  logic [15:0] thresh_q;

  logic        accept;
  logic        vq_push, vq_pop;
  verdict_t    vq_in, vq_out;
  q_status_t   vq_status;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
      thresh_q <= AlarmReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADER_VALUE:    header_q <= cfg_data_i[7:0];
        CFG_ALARM_THRESHOLD: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Held full while the verdict queue has no slot, even for mid-burst bytes.
  assign full   = vq_status.full;
  assign accept = push & ~full;

  sspp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (in_item_i),
    .header_value_i (header_q),
    .verdict_push_o (vq_push),
    .verdict_o      (vq_in)
  );

  sspp_vq u_vq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (vq_push),
    .item_i   (vq_in),
    .pop_i    (vq_pop),
    .status_o (vq_status),
    .item_o   (vq_out)
  );

  sspp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .vq_status_i       (vq_status),
    .verdict_i         (vq_out),
    .vq_pop_o          (vq_pop),
    .alarm_threshold_i (thresh_q),
    .pop_i             (pop),
    .empty_o           (empty),
    .item_o            (out_item_o)
  );

endmodule
